FILE: sv/hpema_pkg.sv
package hpema_pkg;

   // field widths
   localparam int LUMA_W     = 8;
   localparam int HITS_W     = 20;
   localparam int GAIN_W     = 16;
   localparam int READING_W  = 32;
   localparam int WEIGHT_W   = 17;
   localparam int DOSE_W     = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // derived widths of intermediate products
   localparam int PROD_W  = HITS_W + GAIN_W;
   localparam int WPROD_W = 2 * WEIGHT_W;
   localparam int MPROD_W = READING_W + WEIGHT_W;

   // largest frame the hit counter has to cover
   localparam int unsigned MAX_FRAME_PIXELS = 524288;
   localparam logic [HITS_W-1:0] HITS_FIELD_MAX = {HITS_W{1'b1}};
   localparam logic [HITS_W-1:0] HIT_CAP =
      (MAX_FRAME_PIXELS >= (2**HITS_W) - 1) ? HITS_FIELD_MAX : HITS_W'(MAX_FRAME_PIXELS);

   // fixed point constants
   localparam logic [WEIGHT_W-1:0] ONE_Q16   = 17'h10000;
   localparam logic [DOSE_W-1:0]   DOSE_MAX  = {DOSE_W{1'b1}};
   localparam logic [READING_W-1:0] READING_MAX = {READING_W{1'b1}};

   // register reset values
   localparam logic [LUMA_W-1:0]    RST_PIXEL_THRESHOLD = 8'd200;
   localparam logic [GAIN_W-1:0]    RST_DOSE_PER_HIT    = 16'd655;
   localparam logic [GAIN_W-1:0]    RST_READING_FLOOR   = 16'd66;
   localparam logic [WEIGHT_W-1:0]  RST_ALPHA_LOW       = 17'd3277;
   localparam logic [WEIGHT_W-1:0]  RST_ALPHA_HIGH      = 17'd32768;
   localparam logic [READING_W-1:0] RST_ALERT_LEVEL     = 32'd196608;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIXEL_THRESHOLD = 3'd0,
      CSR_DOSE_PER_HIT    = 3'd1,
      CSR_READING_FLOOR   = 3'd2,
      CSR_ALPHA_LOW       = 3'd3,
      CSR_ALPHA_HIGH      = 3'd4,
      CSR_ALERT_LEVEL     = 3'd5
   } csr_index_type;

   // datapath operations for the end-of-frame sequence
   typedef enum logic [3:0] {
      OP_NONE,
      OP_SCALE,
      OP_FLOOR,
      OP_DIFF,
      OP_WMUL,
      OP_WADD,
      OP_MULA,
      OP_MULB,
      OP_SUM,
      OP_ACC
   } op_type;

   // commands from controller to datapath
   typedef struct packed {
      logic   pix_accept;
      logic   pix_emit;
      logic   frame_emit;
      op_type op;
   } cmd_type;

endpackage

FILE: sv/hot_pixel_adaptive_ema_dosimeter_core.sv
// Hot-pixel dosimeter: each accepted luma byte yields one response transaction;
// a pixel at or above the threshold is counted as a hit and reported hot (gray 0).
// A stream with no frame end runs at one pixel per clock, unless the receiver
// stalls, behind a single output register. The pixel flagged as frame end starts
// a sequencer that scales the hit count, applies the floor, derives the adaptive
// weight and runs the Q16 moving average and dose accumulation, one multiply or
// wide add per cycle; input stalls until that pixel's transaction is registered
// from S_OUT. All dose values are unsigned Q16 rad and saturate; the user must
// write csr registers only while the block is idle; the block does not enforce it.
module hot_pixel_adaptive_ema_dosimeter_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [hpema_pkg::LUMA_W-1:0]           req_luma,
   input  logic                                   req_frame_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [hpema_pkg::LUMA_W-1:0]           rsp_gray_level,
   output logic                                   rsp_is_hot,
   output logic                                   rsp_frame_done,
   output logic [hpema_pkg::HITS_W-1:0]           rsp_hit_total,
   output logic [hpema_pkg::READING_W-1:0]        rsp_filtered_dose,
   output logic [hpema_pkg::DOSE_W-1:0]           rsp_dose_sum,
   output logic [hpema_pkg::WEIGHT_W-1:0]         rsp_weight_used,
   output logic                                   rsp_alarm,
   input  logic                                   csr_write_en,
   input  logic [hpema_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hpema_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   hpema_pkg::cmd_type cmd;

   // sequencer and handshake control
   hpema_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_frame_last (req_frame_last),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd)
   );

   // registers, filter math and output payload
   hpema_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_luma          (req_luma),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_gray_level    (rsp_gray_level),
      .rsp_is_hot        (rsp_is_hot),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_filtered_dose (rsp_filtered_dose),
      .rsp_dose_sum      (rsp_dose_sum),
      .rsp_weight_used   (rsp_weight_used),
      .rsp_alarm         (rsp_alarm)
   );

endmodule

FILE: sv/hpema_ctrl.sv
module hpema_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_frame_last,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hpema_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCALE,
      S_FLOOR,
      S_DIFF,
      S_WMUL,
      S_WADD,
      S_MULA,
      S_MULB,
      S_SUM,
      S_ACC,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      accept;

   // output register can take a new transaction this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign accept    = (state_ff == S_IDLE) && req_valid && slot_free;

   assign req_stall = (state_ff != S_IDLE) || !slot_free;
   assign rsp_valid = rsp_valid_ff;

   // next state, commands and output valid
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      cmd.pix_accept = accept;
      cmd.pix_emit   = 1'b0;
      cmd.frame_emit = 1'b0;
      cmd.op         = hpema_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_frame_last) begin
                  state_in = S_SCALE;
               end else begin
                  cmd.pix_emit = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_SCALE: begin
            cmd.op   = hpema_pkg::OP_SCALE;
            state_in = S_FLOOR;
         end
         S_FLOOR: begin
            cmd.op   = hpema_pkg::OP_FLOOR;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.op   = hpema_pkg::OP_DIFF;
            state_in = S_WMUL;
         end
         S_WMUL: begin
            cmd.op   = hpema_pkg::OP_WMUL;
            state_in = S_WADD;
         end
         S_WADD: begin
            cmd.op   = hpema_pkg::OP_WADD;
            state_in = S_MULA;
         end
         S_MULA: begin
            cmd.op   = hpema_pkg::OP_MULA;
            state_in = S_MULB;
         end
         S_MULB: begin
            cmd.op   = hpema_pkg::OP_MULB;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op   = hpema_pkg::OP_SUM;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op   = hpema_pkg::OP_ACC;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.frame_emit = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/hpema_dp.sv
module hpema_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  hpema_pkg::cmd_type                     cmd,
   input  logic [hpema_pkg::LUMA_W-1:0]           req_luma,
   input  logic                                   csr_write_en,
   input  logic [hpema_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hpema_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic [hpema_pkg::LUMA_W-1:0]           rsp_gray_level,
   output logic                                   rsp_is_hot,
   output logic                                   rsp_frame_done,
   output logic [hpema_pkg::HITS_W-1:0]           rsp_hit_total,
   output logic [hpema_pkg::READING_W-1:0]        rsp_filtered_dose,
   output logic [hpema_pkg::DOSE_W-1:0]           rsp_dose_sum,
   output logic [hpema_pkg::WEIGHT_W-1:0]         rsp_weight_used,
   output logic                                   rsp_alarm
);

   // configuration registers
   logic [hpema_pkg::LUMA_W-1:0]    threshold_ff;
   logic [hpema_pkg::GAIN_W-1:0]    dose_per_hit_ff;
   logic [hpema_pkg::GAIN_W-1:0]    floor_ff;
   logic [hpema_pkg::WEIGHT_W-1:0]  alpha_low_ff;
   logic [hpema_pkg::WEIGHT_W-1:0]  alpha_high_ff;
   logic [hpema_pkg::READING_W-1:0] alert_level_ff;

   // filter state
   logic [hpema_pkg::HITS_W-1:0]    hits_ff, hits_in;
   logic [hpema_pkg::READING_W-1:0] smoothed_ff, smoothed_in;
   logic [hpema_pkg::DOSE_W-1:0]    dose_ff, dose_in;

   // end-of-frame working registers
   logic [hpema_pkg::LUMA_W-1:0]    gray_pend_ff, gray_pend_in;
   logic                            hot_pend_ff, hot_pend_in;
   logic [hpema_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [hpema_pkg::READING_W-1:0] reading_ff, reading_in;
   logic                            seed_ff, seed_in;
   logic [hpema_pkg::WEIGHT_W-1:0]  change_ff, change_in;
   logic [hpema_pkg::WPROD_W-1:0]   wprod_ff, wprod_in;
   logic [hpema_pkg::WEIGHT_W-1:0]  weight_ff, weight_in;
   logic [hpema_pkg::MPROD_W-1:0]   pa_ff, pa_in;
   logic [hpema_pkg::MPROD_W-1:0]   pb_ff, pb_in;

   // output payload registers
   logic [hpema_pkg::LUMA_W-1:0]    out_gray_ff, out_gray_in;
   logic                            out_hot_ff, out_hot_in;
   logic                            out_done_ff, out_done_in;
   logic [hpema_pkg::HITS_W-1:0]    out_hits_ff, out_hits_in;
   logic [hpema_pkg::READING_W-1:0] out_filt_ff, out_filt_in;
   logic [hpema_pkg::DOSE_W-1:0]    out_sum_ff, out_sum_in;
   logic [hpema_pkg::WEIGHT_W-1:0]  out_weight_ff, out_weight_in;
   logic                            out_alarm_ff, out_alarm_in;

   // combinational helpers
   logic                            hot;
   logic [hpema_pkg::WEIGHT_W-1:0]  lo_w;
   logic [hpema_pkg::WEIGHT_W-1:0]  hi_w;
   logic                            rising;
   logic [hpema_pkg::WEIGHT_W-1:0]  span;
   logic [hpema_pkg::WEIGHT_W-1:0]  step;
   logic [hpema_pkg::READING_W-1:0] sat_reading;
   logic [hpema_pkg::READING_W-1:0] floor_ext;
   logic [hpema_pkg::READING_W-1:0] diff;
   logic [hpema_pkg::MPROD_W:0]     ema_acc;
   logic [hpema_pkg::DOSE_W:0]      dose_add;

   assign hot       = req_luma >= threshold_ff;
   assign lo_w      = (alpha_low_ff > hpema_pkg::ONE_Q16) ? hpema_pkg::ONE_Q16 : alpha_low_ff;
   assign hi_w      = (alpha_high_ff > hpema_pkg::ONE_Q16) ? hpema_pkg::ONE_Q16 : alpha_high_ff;
   assign rising    = hi_w >= lo_w;
   assign span      = rising ? (hi_w - lo_w) : (lo_w - hi_w);
   assign step      = wprod_ff[hpema_pkg::WEIGHT_W+15:16];
   assign floor_ext = {{(hpema_pkg::READING_W-hpema_pkg::GAIN_W){1'b0}}, floor_ff};
   assign sat_reading = (prod_ff[hpema_pkg::PROD_W-1:hpema_pkg::READING_W] != '0)
                      ? hpema_pkg::READING_MAX : prod_ff[hpema_pkg::READING_W-1:0];
   assign diff      = (reading_ff >= smoothed_ff) ? (reading_ff - smoothed_ff)
                                                  : (smoothed_ff - reading_ff);
   assign ema_acc   = {1'b0, pa_ff} + {1'b0, pb_ff} + (hpema_pkg::MPROD_W+1)'(32768);
   assign dose_add  = {1'b0, dose_ff}
                    + {{(hpema_pkg::DOSE_W-hpema_pkg::READING_W+1){1'b0}}, smoothed_ff};

   // next values of the datapath registers
   always_comb begin
      hits_in       = hits_ff;
      smoothed_in   = smoothed_ff;
      dose_in       = dose_ff;
      gray_pend_in  = gray_pend_ff;
      hot_pend_in   = hot_pend_ff;
      prod_in       = prod_ff;
      reading_in    = reading_ff;
      seed_in       = seed_ff;
      change_in     = change_ff;
      wprod_in      = wprod_ff;
      weight_in     = weight_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      out_gray_in   = out_gray_ff;
      out_hot_in    = out_hot_ff;
      out_done_in   = out_done_ff;
      out_hits_in   = out_hits_ff;
      out_filt_in   = out_filt_ff;
      out_sum_in    = out_sum_ff;
      out_weight_in = out_weight_ff;
      out_alarm_in  = out_alarm_ff;

      // pixel classification and hit counting
      if (cmd.pix_accept) begin
         gray_pend_in = hot ? '0 : req_luma;
         hot_pend_in  = hot;
         if (hot && (hits_ff < hpema_pkg::HIT_CAP)) begin
            hits_in = hits_ff + 1'b1;
         end
      end

      // plain pixel transaction
      if (cmd.pix_emit) begin
         out_gray_in   = hot ? '0 : req_luma;
         out_hot_in    = hot;
         out_done_in   = 1'b0;
         out_hits_in   = '0;
         out_filt_in   = '0;
         out_sum_in    = '0;
         out_weight_in = '0;
         out_alarm_in  = 1'b0;
      end

      // end-of-frame sequence, one step per cycle
      case (cmd.op)
         hpema_pkg::OP_SCALE: begin
            prod_in = hits_ff * dose_per_hit_ff;
         end
         hpema_pkg::OP_FLOOR: begin
            reading_in = ((floor_ff != '0) && (sat_reading < floor_ext)) ? floor_ext
                                                                         : sat_reading;
         end
         hpema_pkg::OP_DIFF: begin
            seed_in   = smoothed_ff == '0;
            change_in = (diff > {{(hpema_pkg::READING_W-hpema_pkg::WEIGHT_W){1'b0}},
                                 hpema_pkg::ONE_Q16})
                      ? hpema_pkg::ONE_Q16 : diff[hpema_pkg::WEIGHT_W-1:0];
         end
         hpema_pkg::OP_WMUL: begin
            wprod_in = span * change_ff;
         end
         hpema_pkg::OP_WADD: begin
            if (seed_ff) begin
               weight_in = lo_w;
            end else if (rising) begin
               weight_in = lo_w + step;
            end else begin
               weight_in = lo_w - step;
            end
         end
         hpema_pkg::OP_MULA: begin
            pa_in = reading_ff * weight_ff;
         end
         hpema_pkg::OP_MULB: begin
            pb_in = smoothed_ff * (hpema_pkg::ONE_Q16 - weight_ff);
         end
         hpema_pkg::OP_SUM: begin
            smoothed_in = seed_ff ? reading_ff : ema_acc[hpema_pkg::READING_W+15:16];
         end
         hpema_pkg::OP_ACC: begin
            dose_in = dose_add[hpema_pkg::DOSE_W] ? hpema_pkg::DOSE_MAX
                                                  : dose_add[hpema_pkg::DOSE_W-1:0];
         end
         default: begin
         end
      endcase

      // frame transaction, hit counter restarts
      if (cmd.frame_emit) begin
         out_gray_in   = gray_pend_ff;
         out_hot_in    = hot_pend_ff;
         out_done_in   = 1'b1;
         out_hits_in   = hits_ff;
         out_filt_in   = smoothed_ff;
         out_sum_in    = dose_ff;
         out_weight_in = weight_ff;
         out_alarm_in  = smoothed_ff > alert_level_ff;
         hits_in       = '0;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= hpema_pkg::RST_PIXEL_THRESHOLD;
         dose_per_hit_ff <= hpema_pkg::RST_DOSE_PER_HIT;
         floor_ff        <= hpema_pkg::RST_READING_FLOOR;
         alpha_low_ff    <= hpema_pkg::RST_ALPHA_LOW;
         alpha_high_ff   <= hpema_pkg::RST_ALPHA_HIGH;
         alert_level_ff  <= hpema_pkg::RST_ALERT_LEVEL;
      end else if (csr_write_en) begin
         case (hpema_pkg::csr_index_type'(csr_index))
            hpema_pkg::CSR_PIXEL_THRESHOLD: threshold_ff    <= csr_wdata[hpema_pkg::LUMA_W-1:0];
            hpema_pkg::CSR_DOSE_PER_HIT:    dose_per_hit_ff <= csr_wdata[hpema_pkg::GAIN_W-1:0];
            hpema_pkg::CSR_READING_FLOOR:   floor_ff        <= csr_wdata[hpema_pkg::GAIN_W-1:0];
            hpema_pkg::CSR_ALPHA_LOW:       alpha_low_ff    <= csr_wdata[hpema_pkg::WEIGHT_W-1:0];
            hpema_pkg::CSR_ALPHA_HIGH:      alpha_high_ff   <= csr_wdata[hpema_pkg::WEIGHT_W-1:0];
            hpema_pkg::CSR_ALERT_LEVEL:     alert_level_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff     <= '0;
         smoothed_ff <= '0;
         dose_ff     <= '0;
      end else begin
         hits_ff     <= hits_in;
         smoothed_ff <= smoothed_in;
         dose_ff     <= dose_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      gray_pend_ff  <= gray_pend_in;
      hot_pend_ff   <= hot_pend_in;
      prod_ff       <= prod_in;
      reading_ff    <= reading_in;
      seed_ff       <= seed_in;
      change_ff     <= change_in;
      wprod_ff      <= wprod_in;
      weight_ff     <= weight_in;
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      out_gray_ff   <= out_gray_in;
      out_hot_ff    <= out_hot_in;
      out_done_ff   <= out_done_in;
      out_hits_ff   <= out_hits_in;
      out_filt_ff   <= out_filt_in;
      out_sum_ff    <= out_sum_in;
      out_weight_ff <= out_weight_in;
      out_alarm_ff  <= out_alarm_in;
   end

   assign rsp_gray_level    = out_gray_ff;
   assign rsp_is_hot        = out_hot_ff;
   assign rsp_frame_done    = out_done_ff;
   assign rsp_hit_total     = out_hits_ff;
   assign rsp_filtered_dose = out_filt_ff;
   assign rsp_dose_sum      = out_sum_ff;
   assign rsp_weight_used   = out_weight_ff;
   assign rsp_alarm         = out_alarm_ff;

endmodule

FILE: sv/hpema_checker.sv
module hpema_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   req_frame_last,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [hpema_pkg::LUMA_W-1:0]           rsp_gray_level,
   input logic                                   rsp_is_hot,
   input logic                                   rsp_frame_done,
   input logic [hpema_pkg::HITS_W-1:0]           rsp_hit_total,
   input logic [hpema_pkg::READING_W-1:0]        rsp_filtered_dose,
   input logic [hpema_pkg::DOSE_W-1:0]           rsp_dose_sum,
   input logic [hpema_pkg::WEIGHT_W-1:0]         rsp_weight_used,
   input logic                                   rsp_alarm
);

   // a plain pixel produces its transaction on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_frame_last) |=> rsp_valid)
      else $error("pixel transaction not presented after acceptance");

   // hot pixels are shown with zero gray
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_hot) |-> (rsp_gray_level == '0))
      else $error("hot pixel carries nonzero gray");

   // frame fields stay zero on pixel transactions
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_done) |->
         (rsp_hit_total == '0 && rsp_filtered_dose == '0 && rsp_dose_sum == '0 &&
          rsp_weight_used == '0 && !rsp_alarm))
      else $error("frame fields set on a pixel transaction");

   // accumulated dose includes the current filtered reading
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |->
         (rsp_dose_sum >= {{(hpema_pkg::DOSE_W-hpema_pkg::READING_W){1'b0}},
                           rsp_filtered_dose}))
      else $error("dose sum below filtered reading");

   // a stalled transaction holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_gray_level) && $stable(rsp_dose_sum)))
      else $error("stalled transaction changed");

endmodule

bind hot_pixel_adaptive_ema_dosimeter_core hpema_checker u_checker (.*);

FILE: test/tb_hot_pixel_adaptive_ema_dosimeter_core.sv
`timescale 1ns / 100ps

module tb_hot_pixel_adaptive_ema_dosimeter_core;

   localparam int CLOCK_PERIOD = 20;
   localparam int CYCLE_LIMIT = 250_000;
   localparam int RANDOM_PIXELS = 800;
   localparam int PHASE_PIXELS = 100;
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CLOSING_FRAME_PIXELS = 24;

   // one response transaction, fields in port order
   typedef struct packed {
      logic [hpema_pkg::LUMA_W-1:0]    gray_level;
      logic                            is_hot;
      logic                            frame_done;
      logic [hpema_pkg::HITS_W-1:0]    hit_total;
      logic [hpema_pkg::READING_W-1:0] filtered_dose;
      logic [hpema_pkg::DOSE_W-1:0]    dose_sum;
      logic [hpema_pkg::WEIGHT_W-1:0]  weight_used;
      logic                            alarm;
   } pixel_result_type;

   // dosimeter predictor plus the queue of responses still owed by the block
   class dose_scoreboard;
      logic [hpema_pkg::LUMA_W-1:0]    threshold;
      logic [hpema_pkg::GAIN_W-1:0]    gain;
      logic [hpema_pkg::GAIN_W-1:0]    floor_level;
      logic [hpema_pkg::WEIGHT_W-1:0]  weight_lo;
      logic [hpema_pkg::WEIGHT_W-1:0]  weight_hi;
      logic [hpema_pkg::READING_W-1:0] alert;
      logic [hpema_pkg::HITS_W-1:0]    hits;
      logic [hpema_pkg::READING_W-1:0] smoothed;
      logic [hpema_pkg::DOSE_W-1:0]    dose_total;
      pixel_result_type                owed_results[$];
      int accepted, checked, frames, hot_pixels, alarms, mismatches;
      logic [hpema_pkg::HITS_W-1:0]    top_hits;

      function new();
         threshold = hpema_pkg::RST_PIXEL_THRESHOLD;
         gain = hpema_pkg::RST_DOSE_PER_HIT;
         floor_level = hpema_pkg::RST_READING_FLOOR;
         weight_lo = hpema_pkg::RST_ALPHA_LOW;
         weight_hi = hpema_pkg::RST_ALPHA_HIGH;
         alert = hpema_pkg::RST_ALERT_LEVEL;
         hits = '0;
         smoothed = '0;
         dose_total = '0;
         top_hits = '0;
      endfunction

      function void set_reg(hpema_pkg::csr_index_type idx,
                            logic [hpema_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            hpema_pkg::CSR_PIXEL_THRESHOLD: threshold = value[hpema_pkg::LUMA_W-1:0];
            hpema_pkg::CSR_DOSE_PER_HIT:    gain = value[hpema_pkg::GAIN_W-1:0];
            hpema_pkg::CSR_READING_FLOOR:   floor_level = value[hpema_pkg::GAIN_W-1:0];
            hpema_pkg::CSR_ALPHA_LOW:       weight_lo = value[hpema_pkg::WEIGHT_W-1:0];
            hpema_pkg::CSR_ALPHA_HIGH:      weight_hi = value[hpema_pkg::WEIGHT_W-1:0];
            hpema_pkg::CSR_ALERT_LEVEL:     alert = value[hpema_pkg::READING_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      // predict the response of one accepted pixel
      function void note_pixel(logic [hpema_pkg::LUMA_W-1:0] luma, logic last);
         pixel_result_type want;
         logic hot;
         logic [63:0] prod, mix;
         logic [hpema_pkg::READING_W-1:0] reading, diff, fresh;
         logic [hpema_pkg::WEIGHT_W-1:0] lo, hi, change, w;
         logic [hpema_pkg::DOSE_W:0] dose_next;
         hot = luma >= threshold;
         want = '0;
         want.gray_level = hot ? '0 : luma;
         want.is_hot = hot;
         accepted++;
         if (hot) hot_pixels++;
         if (hot && hits < hpema_pkg::HIT_CAP) hits++;
         if (last) begin
            // scale and floor the frame reading
            prod = 64'(hits) * 64'(gain);
            reading = (prod > 64'(hpema_pkg::READING_MAX)) ? hpema_pkg::READING_MAX
                                                           : prod[hpema_pkg::READING_W-1:0];
            if (floor_level != 0 && reading < 32'(floor_level)) reading = 32'(floor_level);
            lo = (weight_lo > hpema_pkg::ONE_Q16) ? hpema_pkg::ONE_Q16 : weight_lo;
            hi = (weight_hi > hpema_pkg::ONE_Q16) ? hpema_pkg::ONE_Q16 : weight_hi;
            // seed on an empty filter, else adaptive moving average
            if (smoothed == 0) begin
               w = lo;
               fresh = reading;
            end else begin
               diff = (reading >= smoothed) ? reading - smoothed : smoothed - reading;
               change = (diff > 32'(hpema_pkg::ONE_Q16)) ? hpema_pkg::ONE_Q16
                                                         : diff[hpema_pkg::WEIGHT_W-1:0];
               if (hi >= lo)
                  w = lo + (hpema_pkg::WEIGHT_W)'((64'(hi - lo) * 64'(change)) >> 16);
               else
                  w = lo - (hpema_pkg::WEIGHT_W)'((64'(lo - hi) * 64'(change)) >> 16);
               mix = 64'(reading) * 64'(w)
                   + 64'(smoothed) * 64'(hpema_pkg::ONE_Q16 - w) + 64'd32768;
               fresh = mix[47:16];
            end
            smoothed = fresh;
            // saturating dose sum
            dose_next = {1'b0, dose_total} + (hpema_pkg::DOSE_W + 1)'(fresh);
            dose_total = (dose_next > {1'b0, hpema_pkg::DOSE_MAX})
                       ? hpema_pkg::DOSE_MAX : dose_next[hpema_pkg::DOSE_W-1:0];
            want.frame_done = 1'b1;
            want.hit_total = hits;
            want.filtered_dose = fresh;
            want.dose_sum = dose_total;
            want.weight_used = w;
            want.alarm = fresh > alert;
            frames++;
            if (want.alarm) alarms++;
            if (hits > top_hits) top_hits = hits;
            hits = '0;
         end
         owed_results.push_back(want);
      endfunction

      // compare one response transaction with the oldest prediction
      function void check_result(pixel_result_type got);
         pixel_result_type want;
         bit bad;
         if (owed_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: gray %h hot %b done %b hits %h dose %h",
                        got.gray_level, got.is_hot, got.frame_done, got.hit_total,
                        got.filtered_dose);
            return;
         end
         want = owed_results.pop_front();
         checked++;
         bad = (got.gray_level !== want.gray_level) || (got.is_hot !== want.is_hot)
            || (got.frame_done !== want.frame_done) || (got.hit_total !== want.hit_total)
            || (got.filtered_dose !== want.filtered_dose) || (got.dose_sum !== want.dose_sum)
            || (got.weight_used !== want.weight_used) || (got.alarm !== want.alarm);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d expected: gray %h hot %b done %b hits %h",
                        checked, want.gray_level, want.is_hot, want.frame_done,
                        want.hit_total, "  dose %h sum %h w %h al %b",
                        want.filtered_dose, want.dose_sum, want.weight_used, want.alarm);
               $display("response %0d actual:   gray %h hot %b done %b hits %h",
                        checked, got.gray_level, got.is_hot, got.frame_done,
                        got.hit_total, "  dose %h sum %h w %h al %b",
                        got.filtered_dose, got.dose_sum, got.weight_used, got.alarm);
            end
         end
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic [hpema_pkg::LUMA_W-1:0]          req_luma;
   logic                                  req_frame_last;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic [hpema_pkg::LUMA_W-1:0]          rsp_gray_level;
   logic                                  rsp_is_hot;
   logic                                  rsp_frame_done;
   logic [hpema_pkg::HITS_W-1:0]          rsp_hit_total;
   logic [hpema_pkg::READING_W-1:0]       rsp_filtered_dose;
   logic [hpema_pkg::DOSE_W-1:0]          rsp_dose_sum;
   logic [hpema_pkg::WEIGHT_W-1:0]        rsp_weight_used;
   logic                                  rsp_alarm;
   logic                                  csr_write_en;
   hpema_pkg::csr_index_type              csr_index;
   logic [hpema_pkg::CSR_DATA_W-1:0]      csr_wdata;

   dose_scoreboard board = new();
   logic [hpema_pkg::CSR_DATA_W-1:0] reg_value [6];
   logic [hpema_pkg::LUMA_W-1:0] cur_threshold = hpema_pkg::RST_PIXEL_THRESHOLD;
   int settings_used = 1;
   int cycle_count = 0;
   int hold_request = 0;
   int hold_left = 0;
   int stall_burst = 0;
   bit src_idle_on = 1'b0;
   bit sink_idle_on = 1'b0;

   hot_pixel_adaptive_ema_dosimeter_core DUT (.*);

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response side: random stall bursts and the long hold-off
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset)
         rsp_stall <= 1'b0;
      else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_burst > 0) begin
         rsp_stall <= 1'b1;
         stall_burst--;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_burst = $urandom_range(0, 2);
      end else
         rsp_stall <= 1'b0;
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(pixel_result_type'({rsp_gray_level, rsp_is_hot, rsp_frame_done,
            rsp_hit_total, rsp_filtered_dose, rsp_dose_sum, rsp_weight_used, rsp_alarm}));
   end

   // offer one pixel and hold it until the block takes it
   task automatic send_pixel(input logic [hpema_pkg::LUMA_W-1:0] luma, input logic last);
      if (src_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_luma <= luma;
      req_frame_last <= last;
      do @(posedge clock); while (req_stall);
      board.note_pixel(luma, last);
   endtask

   // luma either in the hot band or below it
   function automatic logic [hpema_pkg::LUMA_W-1:0] pick_luma(input int hot_pct);
      int thr;
      thr = cur_threshold;
      if ($urandom_range(0, 99) < hot_pct)
         return (hpema_pkg::LUMA_W)'(thr + $urandom_range(0, 255 - thr));
      if (thr == 0) return (hpema_pkg::LUMA_W)'($urandom_range(0, 255));
      return (hpema_pkg::LUMA_W)'($urandom_range(0, thr - 1));
   endfunction

   task automatic send_frame(input int len, input int hot_pct);
      for (int i = 0; i < len; i++)
         send_pixel(pick_luma(hot_pct), i == len - 1);
   endtask

   // sender pauses until every owed response is back and the block is quiet
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register value, sometimes with junk above the register width
   function automatic logic [hpema_pkg::CSR_DATA_W-1:0] with_junk(
         input logic [hpema_pkg::CSR_DATA_W-1:0] v, input int width);
      logic [hpema_pkg::CSR_DATA_W-1:0] keep;
      keep = (width >= hpema_pkg::CSR_DATA_W) ? '1
           : (((hpema_pkg::CSR_DATA_W)'(1) << width) - 1);
      if ($urandom_range(0, 1) == 0) return v & keep;
      return (v & keep) | ($urandom() & ~keep);
   endfunction

   task automatic choose_settings(input logic [hpema_pkg::CSR_DATA_W-1:0] thr, gain,
                                  floor_level, alo, ahi, alert);
      reg_value[hpema_pkg::CSR_PIXEL_THRESHOLD] = with_junk(thr, hpema_pkg::LUMA_W);
      reg_value[hpema_pkg::CSR_DOSE_PER_HIT]    = with_junk(gain, hpema_pkg::GAIN_W);
      reg_value[hpema_pkg::CSR_READING_FLOOR]   = with_junk(floor_level, hpema_pkg::GAIN_W);
      reg_value[hpema_pkg::CSR_ALPHA_LOW]       = with_junk(alo, hpema_pkg::WEIGHT_W);
      reg_value[hpema_pkg::CSR_ALPHA_HIGH]      = with_junk(ahi, hpema_pkg::WEIGHT_W);
      reg_value[hpema_pkg::CSR_ALERT_LEVEL]     = alert;
   endtask

   // write all registers back to back
   task automatic program_regs();
      hpema_pkg::csr_index_type idx;
      idx = idx.first();
      do begin
         csr_write_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= reg_value[idx];
         board.set_reg(idx, reg_value[idx]);
         @(posedge clock);
         idx = idx.next();
      end while (idx != idx.first());
      csr_write_en <= 1'b0;
      cur_threshold = reg_value[hpema_pkg::CSR_PIXEL_THRESHOLD][hpema_pkg::LUMA_W-1:0];
      settings_used++;
   endtask

   function automatic logic [hpema_pkg::CSR_DATA_W-1:0] random_weight();
      if ($urandom_range(0, 4) == 0) return $urandom_range(65537, 131071);
      return $urandom_range(0, 65536);
   endfunction

   initial begin
      int start_count, phase_start, phase;
      req_valid <= 1'b0;
      req_luma <= '0;
      req_frame_last <= 1'b0;
      csr_write_en <= 1'b0;
      csr_index <= hpema_pkg::CSR_PIXEL_THRESHOLD;
      csr_wdata <= '0;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames at reset settings: seed, threshold edges, floor, lone pixel
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'd199, 1'b0);
      send_pixel(8'd200, 1'b0);
      send_pixel(8'd201, 1'b1);
      send_pixel(8'hAA, 1'b1);
      send_pixel(8'hFF, 1'b1);
      send_pixel(8'h55, 1'b0);
      send_pixel(8'hFE, 1'b0);
      send_pixel(8'h01, 1'b0);
      send_pixel(8'h80, 1'b0);
      send_pixel(8'h7F, 1'b1);
      send_pixel(8'h00, 1'b1);
      wait_for_results();

      // random phases, the first three at extreme settings
      start_count = board.accepted;
      phase = 0;
      while (board.accepted - start_count < RANDOM_PIXELS) begin
         case (phase)
            0: choose_settings(0, 65535, 65535, 0, 65536, 0);
            1: choose_settings(255, 0, 0, 65536, 65536, 32'hFFFF_FFFF);
            2: choose_settings(128, 65535, 1, 131071, 0, 32'hFFFF_FFFF);
            default:
               choose_settings($urandom_range(0, 255),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 4000),
                  ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535),
                  random_weight(), random_weight(),
                  ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 150000));
         endcase
         program_regs();
         // long receiver hold-off while pixels keep coming
         if (phase == 3) hold_request = LONG_HOLD_CYCLES;
         phase_start = board.accepted;
         while (board.accepted - phase_start < PHASE_PIXELS) begin
            src_idle_on = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
            send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(20, 120)
                                                   : $urandom_range(1, 12),
                       $urandom_range(0, 100));
            if (phase == 4 && board.accepted - phase_start > PHASE_PIXELS / 2
                && $urandom_range(0, 3) == 0)
               wait_for_results();
         end
         wait_for_results();
         phase++;
      end

      // closing part without idling: all-hot frames at the widest gain
      src_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      choose_settings(0, 65535, $urandom_range(0, 65535), random_weight(), random_weight(),
                      $urandom());
      program_regs();
      send_frame(3, 100);
      send_frame(CLOSING_FRAME_PIXELS, 100);
      send_frame(2, 50);
      wait_for_results();

      $display("checked %0d pixel transactions, %0d hot, over %0d frames",
               board.checked, board.hot_pixels, board.frames,
               " and %0d register settings", settings_used);
      $display("alarms raised on %0d frames, largest frame hit count %0d",
               board.alarms, board.top_hits);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
